@@ rtl/kprq_pkg.sv @@
// Package: shared types, codes and limits of the key press/release qualifier.
`default_nettype none
package kprq_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned PIN_COUNT = 8;
  localparam int unsigned PRESS_W   = 16;
  localparam int unsigned REL_W     = 8;
  localparam int unsigned LANE_IW   = 4;   // wide enough for any key number up to 15

  // Default key count
  localparam int unsigned KEY_COUNT_DEF = 8;

  // Timer saturation points
  localparam logic [PRESS_W-1:0] HOLD_MAX    = 16'd60000;
  localparam logic [REL_W-1:0]   RELEASE_MAX = 8'd250;

  // Reset value of the release filter threshold
  localparam logic [REL_W-1:0] FILTER_RESET = 8'd10;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_CLR_EVENT = 2'd1,
    CMD_CLR_HOLD  = 2'd2,
    CMD_NOP       = 2'd3
  } kprq_cmd_t;

  // Per-key phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HELD     = 3'd1,
    PH_RELEASED = 3'd2,
    PH_FILTER   = 3'd3,
    PH_ACCEPT   = 3'd4
  } kprq_phase_t;

  // What one key lane reports to the merge stage
  typedef struct packed {
    logic               lock_set;
    logic               lock_clr;
    logic               event_bit;
    logic [PRESS_W-1:0] hold;
  } kprq_lane_t;

  // One result
  typedef struct packed {
    logic [PIN_COUNT-1:0] key_events;
    logic [PRESS_W-1:0]   held_time;
    logic                 any_key_locked;
    logic                 press_seen;
  } kprq_result_t;

endpackage
`default_nettype wire

@@ rtl/key_press_release_qualifier_top.sv @@
// Key press/release qualifier: lanes per key, merge stage and result buffer.
// A result is written into the result buffer when its request is accepted and is shown from there.
// Throughput: one request per cycle while the input is not stalled; every key lane updates in the same cycle.
// A two-entry result buffer keeps accepting while one result waits; input stalls when full.
// Reset (rst, synchronous, active high) clears all keys to idle, timers, counts and flags to
// zero, and loads the release filter threshold with 10.
`default_nettype none
module key_press_release_qualifier_top
  import kprq_pkg::*;
#(
  parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [IDX_W-1:0]     key_index,
  input  wire logic [PIN_COUNT-1:0] key_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIN_COUNT-1:0]      key_events,
  output logic [PRESS_W-1:0]        held_time,
  output logic                      any_key_locked,
  output logic                      press_seen,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REL_W-1:0]     cfg_data
);

  logic             accept;
  logic             full;
  logic             tick, clr_ev, clr_hd;
  logic [REL_W-1:0] filter_ticks;
  kprq_lane_t       lane_st [KEY_COUNT];
  kprq_result_t     result, out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign tick     = accept && (kprq_cmd_t'(cmd) == CMD_TICK);
  assign clr_ev   = accept && (kprq_cmd_t'(cmd) == CMD_CLR_EVENT);
  assign clr_hd   = accept && (kprq_cmd_t'(cmd) == CMD_CLR_HOLD);

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ticks <= FILTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      filter_ticks <= cfg_data;
    end
  end

  // One lane per key; keys without a pin read released
  for (genvar k = 0; k < int'(KEY_COUNT); k++) begin : g_lane
    logic down;
    logic hit;
    if (k < int'(PIN_COUNT)) begin : g_pin
      assign down = !key_levels[k];
    end else begin : g_nopin
      assign down = 1'b0;
    end
    assign hit = {1'b0, key_index} == LANE_IW'(k);

    kprq_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .clr_event (clr_ev && hit),
      .clr_hold  (clr_hd && hit),
      .down      (down),
      .thr       (filter_ticks),
      .lane_st   (lane_st[k])
    );
  end

  kprq_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_st   (lane_st),
    .key_index (key_index),
    .result    (result)
  );

  kprq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign key_events     = out_data.key_events;
  assign held_time      = out_data.held_time;
  assign any_key_locked = out_data.any_key_locked;
  assign press_seen     = out_data.press_seen;

endmodule
`default_nettype wire

@@ rtl/kprq_lane.sv @@
// One key lane: phase machine, press and release timers, hold count, event latch.
`default_nettype none
module kprq_lane
  import kprq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire logic             clr_event,
  input  wire logic             clr_hold,
  input  wire logic             down,
  input  wire logic [REL_W-1:0] thr,
  output kprq_lane_t            lane_st
);

  kprq_phase_t        phase, phase_next;
  logic [PRESS_W-1:0] press_timer, press_timer_next;
  logic [REL_W-1:0]   release_timer, release_timer_next;
  logic [PRESS_W-1:0] hold_count, hold_count_next;
  logic               event_latch, event_latch_next;

  logic               filtering;
  logic [REL_W-1:0]   rel_eff;
  logic               rel_over;
  logic [PRESS_W-1:0] press_mid;
  logic [REL_W-1:0]   rel_mid;

  // Release timer as seen by the filter check
  assign filtering = (phase == PH_RELEASED) || (phase == PH_FILTER);
  assign rel_eff   = ((phase == PH_RELEASED) || down) ? '0 : release_timer;
  assign rel_over  = rel_eff > thr;

  // Next phase
  always_comb begin
    phase_next = phase;
    if (tick) begin
      unique case (phase)
        PH_IDLE:     if (down) phase_next = PH_HELD;
        PH_HELD:     if (!down) phase_next = PH_RELEASED;
        PH_RELEASED,
        PH_FILTER: begin
          phase_next = PH_FILTER;
          if (down) phase_next = PH_HELD;
          if (rel_over) phase_next = PH_ACCEPT;
        end
        PH_ACCEPT:   phase_next = PH_IDLE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // Timers, hold count, event latch and lane report
  always_comb begin
    press_mid        = (tick && (phase == PH_IDLE) && down) ? '0 : press_timer;
    hold_count_next  = (tick && (phase == PH_HELD)) ? press_timer : hold_count;
    rel_mid          = release_timer;
    if (tick && filtering) begin
      rel_mid = rel_over ? '0 : rel_eff;
    end
    press_timer_next   = press_mid;
    release_timer_next = rel_mid;
    if (tick) begin
      if (press_mid < HOLD_MAX) press_timer_next = press_mid + 1'b1;
      if (rel_mid < RELEASE_MAX) release_timer_next = rel_mid + 1'b1;
    end
    if (clr_hold) begin
      hold_count_next  = '0;
      press_timer_next = '0;
    end
    event_latch_next = event_latch;
    if (tick && (phase == PH_ACCEPT)) event_latch_next = 1'b1;
    if (clr_event) event_latch_next = 1'b0;

    lane_st.lock_set  = tick && (phase == PH_IDLE) && down;
    lane_st.lock_clr  = tick && (phase == PH_ACCEPT);
    lane_st.event_bit = event_latch_next;
    lane_st.hold      = hold_count_next;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      press_timer   <= '0;
      release_timer <= '0;
      hold_count    <= '0;
      event_latch   <= 1'b0;
    end else begin
      phase         <= phase_next;
      press_timer   <= press_timer_next;
      release_timer <= release_timer_next;
      hold_count    <= hold_count_next;
      event_latch   <= event_latch_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kprq_merge.sv @@
// Merge stage: shared lock and seen flags, result assembly from all lanes.
`default_nettype none
module kprq_merge
  import kprq_pkg::*;
#(
  parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kprq_lane_t       lane_st [KEY_COUNT],
  input  wire logic [IDX_W-1:0] key_index,
  output kprq_result_t          result
);

  logic lock, lock_next;
  logic seen, seen_next;
  logic any_set, any_clr;
  logic [PIN_COUNT-1:0] events;
  logic [PRESS_W-1:0]   held;

  // Resolve the lock flag in key order: the highest key that touches it wins
  always_comb begin
    lock_next = lock;
    any_set   = 1'b0;
    any_clr   = 1'b0;
    for (int k = 0; k < int'(KEY_COUNT); k++) begin
      if (lane_st[k].lock_set) lock_next = 1'b1;
      if (lane_st[k].lock_clr) lock_next = 1'b0;
      any_set = any_set | lane_st[k].lock_set;
      any_clr = any_clr | lane_st[k].lock_clr;
    end
    seen_next = seen | any_clr;
  end

  // Gather event bits of the keys that have pins
  for (genvar k = 0; k < int'(PIN_COUNT); k++) begin : g_ev
    if (k < int'(KEY_COUNT)) begin : g_on
      assign events[k] = lane_st[k].event_bit;
    end else begin : g_off
      assign events[k] = 1'b0;
    end
  end

  // Select the addressed key's hold count, zero beyond the keys
  always_comb begin
    held = '0;
    for (int k = 0; k < int'(KEY_COUNT); k++) begin
      if ({1'b0, key_index} == LANE_IW'(k)) held = lane_st[k].hold;
    end
  end

  assign result.key_events     = events;
  assign result.held_time      = held;
  assign result.any_key_locked = lock_next;
  assign result.press_seen     = seen_next;

  // Hold shared flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lock <= 1'b0;
      seen <= 1'b0;
    end else begin
      lock <= lock_next;
      seen <= seen_next;
    end
  end

  a_seen_sticky: assert property (@(posedge clk) disable iff (rst) seen |=> seen)
    else $error("press seen flag dropped without reset");
  a_seen_on_click: assert property (@(posedge clk) disable iff (rst) any_clr |=> seen)
    else $error("click latched but press seen flag not set");
  a_lock_quiet: assert property (@(posedge clk) disable iff (rst)
      (!any_set && !any_clr) |=> $stable(lock))
    else $error("lock flag moved with no press start and no click");

endmodule
`default_nettype wire

@@ rtl/kprq_out_buf.sv @@
// Two-entry result buffer between the merge stage and the output channel.
`default_nettype none
module kprq_out_buf
  import kprq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire kprq_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  wire logic   out_stall,
  output kprq_result_t out_data
);

  kprq_result_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    if (!push && pop) count_next = count - 2'd1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("result buffer lost a request");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
      (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("result buffer repeated a result");

endmodule
`default_nettype wire
